// ===== rtl/kit_pkg.sv =====
// ============================================================================
// kit_pkg
// Shared types and constants for the keyed item table: operation codes,
// result status codes, sequencer states and field widths.
// ============================================================================
`default_nettype none

package kit_pkg;

    // Field widths of the input and result words
    localparam int KEY_W    = 64;
    localparam int TYPE_W   = 16;
    localparam int AMT_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 4;

    // Operation codes carried on the input word
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADKEY   = 3'd3,
        ST_REMOVED  = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_FOUND    = 3'd6
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_CHECK = 3'd1,
        S_SCAN  = 3'd2,
        S_SHIFT = 3'd3,
        S_DONE  = 3'd4
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/kit_if.sv =====
// ============================================================================
// kit_in_if / kit_out_if
// Valid/ready channels for the keyed item table: command words in,
// result words out.
// ============================================================================
`default_nettype none

interface kit_in_if import kit_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [KEY_W-1:0]        item_key;
    logic [TYPE_W-1:0]       item_type;
    logic signed [AMT_W-1:0] amount;

    modport source (output valid, output operation, output item_key,
                    output item_type, output amount, input ready);
    modport sink   (input valid, input operation, input item_key,
                    input item_type, input amount, output ready);
endinterface

interface kit_out_if import kit_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_W-1:0]       slot;
    logic [TYPE_W-1:0]       found_type;
    logic signed [AMT_W-1:0] found_amount;
    logic [COUNT_W-1:0]      entry_count;
    logic                    saturated;

    modport source (output valid, output status, output slot, output found_type,
                    output found_amount, output entry_count, output saturated,
                    input ready);
    modport sink   (input valid, input status, input slot, input found_type,
                    input found_amount, input entry_count, input saturated,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/keyed_item_table.sv =====
// One word is in work at a time: the command is taken in S_IDLE and checked in
// S_CHECK, the slots are walked in S_SCAN, a remove closes the gap in S_SHIFT, and
// the result loads in S_DONE; a rejected command goes from S_CHECK to S_DONE. The next word is taken
// the cycle after the result loads; the single key compare walks one slot a cycle.
// Reset clears the fill count, the sequencer and the output valid; the entry
// memory is not cleared.
// ============================================================================
// keyed_item_table
// Fixed-capacity keyed table held packed in insertion order. A small
// sequencer walks the entry memory one slot per cycle through a shared
// key compare, then merges, appends, shifts down or reports the entry.
// ============================================================================
`default_nettype none

module keyed_item_table import kit_pkg::*; #(
    parameter int CAPACITY = 10
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    kit_in_if.sink     i_in,
    kit_out_if.source  o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Entry memory
    logic [KEY_W-1:0]        key_mem  [CAPACITY];
    logic [TYPE_W-1:0]       type_mem [CAPACITY];
    logic signed [AMT_W-1:0] amt_mem  [CAPACITY];

    logic [KEY_W-1:0]        r_rd_key;
    logic [TYPE_W-1:0]       r_rd_type;
    logic signed [AMT_W-1:0] r_rd_amt;

    // Sequencer and command registers
    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [TYPE_W-1:0]       r_type, n_type;
    logic signed [AMT_W-1:0] r_amt, n_amt;
    logic [CW-1:0]           r_fill, n_fill;
    logic [CW-1:0]           r_idx, n_idx;

    // Pending result
    t_status                 r_status, n_status;
    logic [CW-1:0]           r_slot, n_slot;
    logic [TYPE_W-1:0]       r_ftype, n_ftype;
    logic signed [AMT_W-1:0] r_famt, n_famt;
    logic                    r_sat, n_sat;

    // Output register
    logic                    r_out_valid;
    t_status                 r_o_status;
    logic [CW-1:0]           r_o_slot;
    logic [TYPE_W-1:0]       r_o_ftype;
    logic signed [AMT_W-1:0] r_o_famt;
    logic [CW-1:0]           r_o_count;
    logic                    r_o_sat;

    // Memory control
    logic [AW-1:0]           w_raddr;
    logic [AW-1:0]           w_waddr;
    logic                    w_we_all;
    logic                    w_we_amt;
    logic signed [AMT_W-1:0] w_wamt;

    logic                    w_ready;
    logic                    w_load;
    logic                    w_out_free;
    logic                    w_hit;
    logic                    w_last;
    logic                    w_full;
    logic                    w_reject;
    logic [CW:0]             w_idx_inc;
    logic signed [AMT_W:0]   w_sum;
    logic signed [AMT_W-1:0] w_sum_sat;
    logic                    w_ovf;

    // Shared compare and saturating adder
    assign w_idx_inc  = {1'b0, r_idx} + 1'b1;
    assign w_hit      = (r_idx < r_fill) && (r_rd_key == r_key);
    assign w_last     = (w_idx_inc >= {1'b0, r_fill});
    assign w_full     = (r_fill == CAP_C);
    assign w_reject   = ((r_op == OP_INSERT) && (w_full || (r_key == '0)))
                        || (r_op == OP_UNUSED);
    assign w_sum      = {r_rd_amt[AMT_W-1], r_rd_amt} + {r_amt[AMT_W-1], r_amt};
    assign w_ovf      = (w_sum[AMT_W] != w_sum[AMT_W-1]);
    assign w_sum_sat  = w_ovf ? (w_sum[AMT_W] ? {1'b1, {(AMT_W-1){1'b0}}}
                                              : {1'b0, {(AMT_W-1){1'b1}}})
                              : w_sum[AMT_W-1:0];
    assign w_out_free = !r_out_valid || o_out.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = w_reject ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = ((r_op == OP_REMOVE) && !w_last) ? S_SHIFT : S_DONE;
                end else if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (w_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        w_ready  = 1'b0;
        w_load   = 1'b0;
        w_raddr  = r_idx[AW-1:0];
        w_waddr  = r_idx[AW-1:0];
        w_we_all = 1'b0;
        w_we_amt = 1'b0;
        w_wamt   = r_amt;
        n_op     = r_op;
        n_key    = r_key;
        n_type   = r_type;
        n_amt    = r_amt;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_status = r_status;
        n_slot   = r_slot;
        n_ftype  = r_ftype;
        n_famt   = r_famt;
        n_sat    = r_sat;
        case (r_state)
            S_IDLE: begin
                // take the command word
                w_ready = 1'b1;
                if (i_in.valid) begin
                    n_op   = t_op'(i_in.operation);
                    n_key  = i_in.item_key;
                    n_type = i_in.item_type;
                    n_amt  = i_in.amount;
                    n_idx  = '0;
                end
            end
            S_CHECK: begin
                // start the read of slot 0 and preset a miss
                w_raddr  = '0;
                n_status = ST_NOTFOUND;
                n_slot   = '0;
                n_ftype  = '0;
                n_famt   = '0;
                n_sat    = 1'b0;
                if ((r_op == OP_INSERT) && w_full) begin
                    n_status = ST_FULL;
                end else if ((r_op == OP_INSERT) && (r_key == '0)) begin
                    n_status = ST_BADKEY;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_slot = r_idx;
                    case (r_op)
                        OP_INSERT: begin
                            // merge with saturation
                            w_we_amt = 1'b1;
                            w_wamt   = w_sum_sat;
                            n_status = ST_MERGED;
                            n_famt   = w_sum_sat;
                            n_sat    = w_ovf;
                        end
                        OP_LOOKUP: begin
                            n_status = ST_FOUND;
                            n_ftype  = r_rd_type;
                            n_famt   = r_rd_amt;
                        end
                        OP_REMOVE: begin
                            n_status = ST_REMOVED;
                            if (w_last) begin
                                n_fill = r_fill - 1'b1;
                            end else begin
                                w_raddr = w_idx_inc[AW-1:0];
                                n_idx   = w_idx_inc[CW-1:0];
                            end
                        end
                        default: n_status = ST_NOTFOUND;
                    endcase
                end else if (w_last) begin
                    if (r_op == OP_INSERT) begin
                        // append at the end of the table
                        w_we_all = 1'b1;
                        w_waddr  = r_fill[AW-1:0];
                        n_status = ST_INSERTED;
                        n_slot   = r_fill;
                        n_famt   = r_amt;
                        n_fill   = r_fill + 1'b1;
                    end
                end else begin
                    // advance to the next slot
                    w_raddr = w_idx_inc[AW-1:0];
                    n_idx   = w_idx_inc[CW-1:0];
                end
            end
            S_SHIFT: begin
                // move the entry at r_idx down one slot
                w_we_all = 1'b1;
                w_waddr  = AW'(r_idx - 1'b1);
                if (w_last) begin
                    n_fill = r_fill - 1'b1;
                end else begin
                    w_raddr = w_idx_inc[AW-1:0];
                    n_idx   = w_idx_inc[CW-1:0];
                end
            end
            S_DONE: begin
                w_load = w_out_free;
            end
            default: w_ready = 1'b0;
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we_all) begin
            if (r_state == S_SHIFT) begin
                key_mem[w_waddr]  <= r_rd_key;
                type_mem[w_waddr] <= r_rd_type;
                amt_mem[w_waddr]  <= r_rd_amt;
            end else begin
                key_mem[w_waddr]  <= r_key;
                type_mem[w_waddr] <= r_type;
                amt_mem[w_waddr]  <= r_amt;
            end
        end else if (w_we_amt) begin
            amt_mem[w_waddr] <= w_wamt;
        end
        r_rd_key  <= key_mem[w_raddr];
        r_rd_type <= type_mem[w_raddr];
        r_rd_amt  <= amt_mem[w_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command, pending result and output payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_type   <= n_type;
        r_amt    <= n_amt;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_ftype  <= n_ftype;
        r_famt   <= n_famt;
        r_sat    <= n_sat;
        if (w_load) begin
            r_o_status <= r_status;
            r_o_slot   <= r_slot;
            r_o_ftype  <= r_ftype;
            r_o_famt   <= r_famt;
            r_o_count  <= r_fill;
            r_o_sat    <= r_sat;
        end
    end

    assign i_in.ready         = w_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_o_status;
    assign o_out.slot         = SLOT_W'(r_o_slot);
    assign o_out.found_type   = r_o_ftype;
    assign o_out.found_amount = r_o_famt;
    assign o_out.entry_count  = COUNT_W'(r_o_count);
    assign o_out.saturated    = r_o_sat;

    // Fill count never passes capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP_C)
        else $error("fill count above capacity");

    // A rejected command leaves the fill count alone
    a_reject_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && w_reject) |=> r_fill == $past(r_fill))
        else $error("rejected command changed fill count");

    // The search index stays inside the filled part of the table
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_fill != '0) |-> r_idx < r_fill)
        else $error("search index beyond fill count");

    // Finishing a shift drops exactly one entry
    a_shift_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && w_last) |=> r_fill == CW'($past(r_fill) - 1'b1))
        else $error("remove did not drop one entry");

endmodule

`default_nettype wire

// ===== test/keyed_item_table_test.sv =====
// ============================================================================
// keyed_item_table_test
// Self-checking bench for the keyed item table. A short table of directed
// words covers reset, zero keys, the unused opcode, saturating merges at both
// ends, a full table and removal at the ends. A long random run over a small
// key pool follows, holding the table near full. Typed directed rows are checked
// against their written results, all others against a behavioral model kept in the bench.
// ============================================================================
`timescale 1ns / 1ps

module keyed_item_table_test;
    import kit_pkg::*;

    localparam int TABLE_DEPTH  = 10;
    localparam int RANDOM_WORDS = 850;
    localparam int POOL_SIZE    = 16;
    localparam int IDLE_PCT     = 9;
    localparam int CALM_FIRST   = 400;
    localparam int CALM_LAST    = 550;
    localparam int PRESSURE_AT  = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam longint AMT_MAX  = 2147483647;
    localparam longint AMT_MIN  = -AMT_MAX - 1;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;

    typedef struct {
        t_op                     op;
        logic [KEY_W-1:0]        key;
        logic [TYPE_W-1:0]       kind;
        logic signed [AMT_W-1:0] amt;
    } table_cmd_t;

    typedef struct {
        t_status                 status;
        logic [SLOT_W-1:0]       slot;
        logic [TYPE_W-1:0]       ftype;
        logic signed [AMT_W-1:0] famt;
        logic [COUNT_W-1:0]      count;
        logic                    sat;
    } table_result_t;

    typedef struct {
        table_cmd_t    cmd;
        bit            typed;
        table_result_t res;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kit_in_if  cmd_ch ();
    kit_out_if res_ch ();

    keyed_item_table #(.CAPACITY(TABLE_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    // Model of the table contents
    logic [KEY_W-1:0]        model_keys    [TABLE_DEPTH];
    logic [TYPE_W-1:0]       model_types   [TABLE_DEPTH];
    logic signed [AMT_W-1:0] model_amounts [TABLE_DEPTH];
    int                      model_fill;

    stim_row_t        directed_rows[$];
    table_result_t    pending_results[$];
    table_result_t    oldest_result;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int error_count     = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int hold_left       = 0;
    bit pressure_done   = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one command word to the model and return the result it produces
    function automatic table_result_t apply_command(input table_cmd_t c);
        table_result_t r;
        int            hit;
        longint        total;
        r.status = ST_NOTFOUND;
        r.slot   = '0;
        r.ftype  = '0;
        r.famt   = '0;
        r.sat    = 1'b0;
        hit      = -1;
        // first match wins, only occupied slots are searched
        for (int i = 0; i < model_fill; i++)
            if (hit < 0 && model_keys[i] == c.key) hit = i;
        case (c.op)
            OP_INSERT: begin
                if (model_fill >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else if (c.key == '0) begin
                    r.status = ST_BADKEY;
                end else if (hit >= 0) begin
                    total = longint'(model_amounts[hit]) + longint'(c.amt);
                    if (total > AMT_MAX) begin
                        total = AMT_MAX;
                        r.sat = 1'b1;
                    end else if (total < AMT_MIN) begin
                        total = AMT_MIN;
                        r.sat = 1'b1;
                    end
                    model_amounts[hit] = total[AMT_W-1:0];
                    r.status = ST_MERGED;
                    r.slot   = hit[SLOT_W-1:0];
                    r.famt   = model_amounts[hit];
                end else begin
                    model_keys[model_fill]    = c.key;
                    model_types[model_fill]   = c.kind;
                    model_amounts[model_fill] = c.amt;
                    r.status = ST_INSERTED;
                    r.slot   = model_fill[SLOT_W-1:0];
                    r.famt   = c.amt;
                    model_fill++;
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    // close the gap left by the removed entry
                    for (int i = hit; i < model_fill - 1; i++) begin
                        model_keys[i]    = model_keys[i+1];
                        model_types[i]   = model_types[i+1];
                        model_amounts[i] = model_amounts[i+1];
                    end
                    model_fill--;
                    r.status = ST_REMOVED;
                    r.slot   = hit[SLOT_W-1:0];
                end
            end
            OP_LOOKUP: begin
                if (hit >= 0) begin
                    r.status = ST_FOUND;
                    r.slot   = hit[SLOT_W-1:0];
                    r.ftype  = model_types[hit];
                    r.famt   = model_amounts[hit];
                end
            end
            default: begin
            end
        endcase
        r.count = model_fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void add_row(
        input t_op op, input logic [KEY_W-1:0] key, input logic [TYPE_W-1:0] kind,
        input logic signed [AMT_W-1:0] amt, input bit typed, input t_status status,
        input logic [SLOT_W-1:0] slot, input logic [TYPE_W-1:0] ftype,
        input logic signed [AMT_W-1:0] famt, input logic [COUNT_W-1:0] count,
        input logic sat
    );
        stim_row_t row;
        row.cmd.op     = op;
        row.cmd.key    = key;
        row.cmd.kind   = kind;
        row.cmd.amt    = amt;
        row.typed      = typed;
        row.res.status = status;
        row.res.slot   = slot;
        row.res.ftype  = ftype;
        row.res.famt   = famt;
        row.res.count  = count;
        row.res.sat    = sat;
        directed_rows.push_back(row);
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Offer one word, with random idle cycles ahead of it, and wait for accept
    task automatic send_word(input table_cmd_t c);
        while (!(words_sent >= CALM_FIRST && words_sent < CALM_LAST) &&
               $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= c.op;
        cmd_ch.item_key  <= c.key;
        cmd_ch.item_type <= c.kind;
        cmd_ch.amount    <= c.amt;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Result side: check each accepted word, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d slot %0d", $time,
                         res_ch.status, res_ch.slot);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                compare_field("status", oldest_result.status, res_ch.status);
                compare_field("slot", oldest_result.slot, res_ch.slot);
                compare_field("found_type", oldest_result.ftype, res_ch.found_type);
                compare_field("found_amount", oldest_result.famt, res_ch.found_amount);
                compare_field("entry_count", oldest_result.count, res_ch.entry_count);
                compare_field("saturated", oldest_result.sat, res_ch.saturated);
            end
            results_checked++;
        end
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (!pressure_done && results_checked >= PRESSURE_AT) begin
            // long hold-off so the table backs up into the command side
            pressure_done = 1'b1;
            hold_left     = HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= (results_checked >= CALM_FIRST && results_checked < CALM_LAST) ||
                            ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stimulus
    initial begin
        table_cmd_t    cmd;
        table_result_t predicted;
        int            pick;

        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= OP_INSERT;
        cmd_ch.item_key  <= '0;
        cmd_ch.item_type <= '0;
        cmd_ch.amount    <= '0;
        model_fill = 0;

        // small key pool so searches hit often; keep every pool key nonzero
        key_pool[0] = KEY_ONES;
        key_pool[1] = 64'd1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
            if (key_pool[i] == '0) key_pool[i] = 64'(i);
        end

        // empty table, zero key, unused opcode
        add_row(OP_LOOKUP, 64'd1, 16'h0000, 32'sd0, 1, ST_NOTFOUND, 0, 0, 0, 0, 0);
        add_row(OP_REMOVE, KEY_ONES, 16'hFFFF, -32'sd1, 1, ST_NOTFOUND, 0, 0, 0, 0, 0);
        add_row(OP_INSERT, 64'd0, 16'h1234, 32'sd5, 1, ST_BADKEY, 0, 0, 0, 0, 0);
        add_row(OP_UNUSED, 64'd1, 16'hFFFF, 32'sh7FFF_FFFF, 1, ST_NOTFOUND, 0, 0, 0, 0, 0);
        // saturating merges at both ends of the range
        add_row(OP_INSERT, KEY_ONES, 16'hFFFF, 32'sh7FFF_FFFF, 1, ST_INSERTED,
                0, 0, 32'sh7FFF_FFFF, 1, 0);
        add_row(OP_INSERT, KEY_ONES, 16'h0000, 32'sd1, 1, ST_MERGED,
                0, 0, 32'sh7FFF_FFFF, 1, 1);
        add_row(OP_INSERT, 64'd1, 16'h0000, 32'sh8000_0000, 1, ST_INSERTED,
                1, 0, 32'sh8000_0000, 2, 0);
        add_row(OP_INSERT, 64'd1, 16'hFFFF, -32'sd1, 1, ST_MERGED,
                1, 0, 32'sh8000_0000, 2, 1);
        add_row(OP_LOOKUP, KEY_ONES, 16'h0000, 32'sd0, 1, ST_FOUND,
                0, 16'hFFFF, 32'sh7FFF_FFFF, 2, 0);
        // a zero key is never stored
        add_row(OP_LOOKUP, 64'd0, 16'h0000, 32'sd0, 1, ST_NOTFOUND, 0, 0, 0, 2, 0);
        add_row(OP_REMOVE, 64'd0, 16'h0000, 32'sd0, 1, ST_NOTFOUND, 0, 0, 0, 2, 0);
        add_row(OP_INSERT, 64'd1, 16'h0000, 32'sh7FFF_FFFF, 0, ST_NOTFOUND, 0, 0, 0, 0, 0);
        // fill the table
        for (int k = 2; k < TABLE_DEPTH; k++)
            add_row(OP_INSERT, 64'(k), 16'(k * 257), 32'(k * 1000 - 4000), 0,
                    ST_NOTFOUND, 0, 0, 0, 0, 0);
        // full table rejects merges, zero keys and new keys alike
        add_row(OP_INSERT, 64'd1, 16'h0000, 32'sd1, 1, ST_FULL, 0, 0, 0, 10, 0);
        add_row(OP_INSERT, 64'd0, 16'h0000, 32'sd1, 1, ST_FULL, 0, 0, 0, 10, 0);
        add_row(OP_INSERT, 64'hA5A5_5A5A_A5A5_5A5A, 16'h5A5A, 32'sd7, 1, ST_FULL,
                0, 0, 0, 10, 0);
        // remove first, last and a middle entry
        add_row(OP_REMOVE, KEY_ONES, 16'h0000, 32'sd0, 1, ST_REMOVED, 0, 0, 0, 9, 0);
        add_row(OP_REMOVE, 64'd9, 16'h0000, 32'sd0, 0, ST_NOTFOUND, 0, 0, 0, 0, 0);
        add_row(OP_LOOKUP, 64'd5, 16'h0000, 32'sd0, 0, ST_NOTFOUND, 0, 0, 0, 0, 0);
        add_row(OP_REMOVE, 64'd4, 16'h0000, 32'sd0, 0, ST_NOTFOUND, 0, 0, 0, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[n]) begin
            send_word(directed_rows[n].cmd);
            predicted = apply_command(directed_rows[n].cmd);
            if (directed_rows[n].typed)
                pending_results.push_back(directed_rows[n].res);
            else
                pending_results.push_back(predicted);
        end

        // random words over the key pool, with some noise keys
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 45)      cmd.op = OP_INSERT;
            else if (pick < 75) cmd.op = OP_REMOVE;
            else if (pick < 96) cmd.op = OP_LOOKUP;
            else                cmd.op = OP_UNUSED;
            pick = $urandom_range(99);
            if (pick < 85)      cmd.key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 95) cmd.key = {$urandom, $urandom};
            else                cmd.key = '0;
            cmd.kind = 16'($urandom);
            // bias amounts toward the range ends to reach saturation
            case ($urandom_range(3))
                0:       cmd.amt = 32'($urandom_range(200)) - 32'sd100;
                1:       cmd.amt = 32'sh7FFF_FFFF - 32'($urandom_range(1000));
                2:       cmd.amt = 32'sh8000_0000 + 32'($urandom_range(1000));
                default: cmd.amt = $urandom;
            endcase
            send_word(cmd);
            pending_results.push_back(apply_command(cmd));
        end
        cmd_ch.valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("keyed_item_table: match");
        else
            $display("keyed_item_table: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("keyed_item_table: mismatch");
        $finish;
    end

endmodule
